@@ rtl/kmp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and codes for the rotation matcher
// Command codes of the input word and the control bundle that drives the
// row of matcher cells.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam logic [1:0] CMD_APPEND  = 2'd0;
	localparam logic [1:0] CMD_TEXT    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	typedef struct packed {
		logic       load;   // store the symbol in the cell at the current length
		logic       step;   // advance the prefix bits by one text byte
		logic       flush;  // drop all prefix bits (on append, clear and restart)
		logic [7:0] sym;
	} kmp_cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/kmp_rotation_matcher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_rotation_matcher: prefix matcher for cyclic-shift search
// Pattern bytes are appended into a row of cells; text bytes then step the
// prefix bits along the row. The longest matching prefix gives the matched
// length, the match flag and the start index of each text byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  in      | in_valid/in_ready  | cmd, symbol
//  out     | out_valid/out_ready| match, start_index, matched_length
//
// Append, clear and restart words give no result.
// A text word passes through the cell row register, the registered levels
// of the highest-bit tree and the output register.
// Reset empties the pattern and restarts the text; cell bytes are not cleared.
// A result waiting at the output stalls the next text word only in its done
// state; no new word is taken while a text word is in flight.
// ----------------------------------------------------------------------------
module kmp_rotation_matcher
	import kmp_pkg::*;
#(
	parameter  int MAX_PATTERN = 256,
	parameter  int INDEX_BITS  = 16,
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            cmd,
	input  wire logic [7:0]            symbol,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       match,
	output logic [INDEX_BITS-1:0]      start_index,
	output logic [LEN_W-1:0]           matched_length
);

	localparam int LVL = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 0;
	localparam int IB  = (LVL > 0) ? LVL : 1;
	localparam int LAT = LVL / 3;
	localparam int CW  = (LAT > 0) ? $clog2(LAT + 1) : 1;
	localparam int SW  = (INDEX_BITS + 1 > LEN_W) ? INDEX_BITS + 1 : LEN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [LEN_W-1:0]      len_q;
	logic [INDEX_BITS-1:0] pos_q;
	logic [INDEX_BITS-1:0] cur_q;
	logic                  out_valid_q;
	logic                  match_q;
	logic [INDEX_BITS-1:0] start_q;
	logic [LEN_W-1:0]      mlen_q;

	logic                  acc;
	logic                  room;
	logic                  do_append;
	logic                  do_text;
	logic                  finish;
	kmp_cell_ctrl_t        cell_ctrl;
	logic [MAX_PATTERN-1:0] hit;
	logic                  found;
	logic [IB-1:0]         top_idx;
	logic [LEN_W-1:0]      k;
	logic [SW-1:0]         k_x;
	logic [SW-1:0]         cur1;
	logic [SW-1:0]         start_x;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign room      = (len_q < LEN_W'(MAX_PATTERN));
	assign do_append = acc && (cmd == CMD_APPEND) && room;
	assign do_text   = acc && (cmd == CMD_TEXT);
	assign finish    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cell_ctrl.load  = do_append;
		cell_ctrl.step  = do_text;
		cell_ctrl.flush = do_append ||
		                  (acc && ((cmd == CMD_CLEAR) || (cmd == CMD_RESTART)));
		cell_ctrl.sym   = symbol;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
			logic d_prev;
			if (g == 0) begin : g_head
				assign d_prev = 1'b1;
			end else begin : g_link
				assign d_prev = hit[g-1];
			end
			kmp_cell #(
				.IDX   (g),
				.LEN_W (LEN_W)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cell_ctrl),
				.len    (len_q),
				.d_prev (d_prev),
				.d      (hit[g])
			);
		end
	endgenerate

	kmp_tree #(
		.N (MAX_PATTERN)
	) u_tree (
		.clk   (clk),
		.bits  (hit),
		.found (found),
		.idx   (top_idx)
	);

	// The highest live prefix bit is the longest pattern prefix ending here.
	assign k       = found ? (LEN_W'(top_idx) + LEN_W'(1)) : '0;
	assign k_x     = SW'(k);
	assign cur1    = SW'(cur_q) + SW'(1);
	assign start_x = ((k == '0) || (k_x > cur1)) ? '0 : (cur1 - k_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				case (cmd)
					CMD_APPEND: begin
						if (room) begin
							len_q <= len_q + LEN_W'(1);
							pos_q <= '0;
						end
					end
					CMD_TEXT: begin
						if (!(&pos_q)) begin
							pos_q <= pos_q + INDEX_BITS'(1);
						end
					end
					CMD_CLEAR: begin
						len_q <= '0;
						pos_q <= '0;
					end
					CMD_RESTART: begin
						pos_q <= '0;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (do_text) begin
						if (LAT == 0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WAIT;
							cnt_q   <= CW'(LAT);
						end
					end
				end
				ST_WAIT: begin
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_text) begin
			cur_q <= pos_q;
		end
		if (finish) begin
			match_q <= found && (k == len_q);
			start_q <= INDEX_BITS'(start_x);
			mlen_q  <= k;
		end
	end

	assign out_valid      = out_valid_q;
	assign match          = match_q;
	assign start_index    = start_q;
	assign matched_length = mlen_q;

	// A full match always reports a nonempty prefix.
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match) |-> (matched_length != '0))
		else $error("match reported with an empty prefix");

	// The matched length never exceeds the stored pattern when it is loaded.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (k <= len_q))
		else $error("matched length beyond pattern length");

	// A text word always leaves the idle state to produce its result.
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_text |=> ((state_q == ST_WAIT) || (state_q == ST_DONE)))
		else $error("text word accepted without starting a lookup");

	// The pattern never grows past its storage.
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PATTERN))
		else $error("pattern length overflow");

endmodule
`default_nettype wire

@@ rtl/kmp_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_cell: one position of the pattern
// Holds one pattern byte and the bit that says the pattern prefix ending at
// this position matches the text ending at the latest byte. The bit moves
// one cell up the row with each text byte.
// ----------------------------------------------------------------------------
module kmp_cell
	import kmp_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int LEN_W = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kmp_cell_ctrl_t   ctrl,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic             d_prev,
	output logic                  d
);

	logic [7:0] p_q;
	logic       d_q;
	logic       sel;
	logic       active;

	assign sel    = (len == LEN_W'(IDX));
	assign active = (LEN_W'(IDX) < len);

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			p_q <= ctrl.sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= 1'b0;
		end else if (ctrl.flush) begin
			d_q <= 1'b0;
		end else if (ctrl.step) begin
			d_q <= d_prev && active && (p_q == ctrl.sym);
		end
	end

	assign d = d_q;

endmodule
`default_nettype wire

@@ rtl/kmp_tree.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_tree: highest set bit of the prefix row
// Binary tree that finds the highest set bit. Nodes at every third level
// above the leaves are registered.
// ----------------------------------------------------------------------------
module kmp_tree #(
	parameter  int N   = 256,
	localparam int LVL = (N > 1) ? $clog2(N) : 0,
	localparam int IB  = (LVL > 0) ? LVL : 1
) (
	input  wire logic          clk,
	input  wire logic [N-1:0]  bits,
	output logic               found,
	output logic [IB-1:0]      idx
);

	localparam int NP = 1 << LVL;

	// Heap layout: node 1 is the root, leaves sit at NP .. 2*NP-1.
	logic          node_v [1:2*NP-1];
	logic [IB-1:0] node_i [1:2*NP-1];

	genvar g;
	generate
		for (g = 0; g < NP; g++) begin : g_leaf
			if (g < N) begin : g_used
				assign node_v[NP+g] = bits[g];
			end else begin : g_pad
				assign node_v[NP+g] = 1'b0;
			end
			assign node_i[NP+g] = IB'(g);
		end

		for (g = 1; g < NP; g++) begin : g_node
			localparam int DEP = $clog2(g + 1) - 1;
			localparam int HT  = LVL - DEP;
			logic          sv;
			logic [IB-1:0] si;

			assign sv = node_v[2*g] | node_v[2*g+1];
			assign si = node_v[2*g+1] ? node_i[2*g+1] : node_i[2*g];

			if ((HT % 3) == 0) begin : g_reg
				logic          v_q;
				logic [IB-1:0] i_q;
				always_ff @(posedge clk) begin
					v_q <= sv;
					i_q <= si;
				end
				assign node_v[g] = v_q;
				assign node_i[g] = i_q;
			end else begin : g_comb
				assign node_v[g] = sv;
				assign node_i[g] = si;
			end
		end
	endgenerate

	assign found = node_v[1];
	assign idx   = node_i[1];

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for kmp_rotation_matcher
// Appends patterns, streams text over valid/ready with random gaps on both
// sides, and predicts every text result with a software KMP automaton. The
// run covers short directed cases, a full 256-byte pattern, and random
// rotation searches and noise.
// ----------------------------------------------------------------------------
module tb_top;
	import kmp_pkg::*;

	localparam int PAT_MAX = 256;
	localparam int IDX_W = 16;
	localparam int LEN_BITS = 9;
	localparam logic [IDX_W-1:0] IDX_TOP = '1;
	localparam int IDLE_MAX = 16;
	localparam int RANDOM_WORDS = 250;
	localparam longint RUN_LIMIT_NS = 4_000_000;

	typedef struct packed {
		logic                hit;
		logic [IDX_W-1:0]    start;
		logic [LEN_BITS-1:0] len;
	} step_result_t;

	class rotation_scoreboard;
		bit [7:0]          pat_bytes [PAT_MAX];
		bit [LEN_BITS-1:0] fail_len [PAT_MAX];
		int unsigned       pat_len;
		int unsigned       prefix_len;
		bit [IDX_W-1:0]    text_pos;
		step_result_t      pending_steps [$];
		int unsigned       errors;
		int unsigned       mismatches;
		int unsigned       results_seen;
		int unsigned       hits_seen;
		int unsigned       dropped_appends;

		// Longest prefix after extending prefix state k by byte c.
		function int unsigned extend_prefix(int unsigned k, bit [7:0] c);
			while (k > 0 && pat_bytes[k] != c)
				k = fail_len[k - 1];
			if (pat_bytes[k] == c)
				k++;
			return k;
		endfunction

		function void take_word(logic [1:0] c, logic [7:0] s);
			step_result_t r;
			int unsigned  k;
			int unsigned  next_idx;
			case (c)
				CMD_APPEND: begin
					if (pat_len < PAT_MAX) begin
						pat_bytes[pat_len] = s;
						fail_len[pat_len] = (pat_len == 0) ? '0 :
							LEN_BITS'(extend_prefix(fail_len[pat_len - 1], s));
						pat_len++;
						prefix_len = 0;
						text_pos = '0;
					end else begin
						dropped_appends++;
					end
				end
				CMD_CLEAR: begin
					pat_len = 0;
					prefix_len = 0;
					text_pos = '0;
				end
				CMD_RESTART: begin
					prefix_len = 0;
					text_pos = '0;
				end
				CMD_TEXT: begin
					k = 0;
					r = '0;
					if (pat_len > 0) begin
						// After a full match, fall back through the last failure value.
						k = (prefix_len >= pat_len) ? fail_len[pat_len - 1] : prefix_len;
						k = extend_prefix(k, s);
						r.hit = (k == pat_len);
						next_idx = int'(text_pos) + 1;
						if (k > 0)
							r.start = (k > next_idx) ? '0 : IDX_W'(next_idx - k);
					end
					r.len = LEN_BITS'(k);
					prefix_len = k;
					if (text_pos != IDX_TOP)
						text_pos++;
					pending_steps = {pending_steps, r};
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic hit, logic [IDX_W-1:0] start,
				logic [LEN_BITS-1:0] len);
			step_result_t want;
			results_seen++;
			if (hit === 1'b1)
				hits_seen++;
			if (pending_steps.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result match=%0d start=%0d len=%0d",
						$time, hit, start, len);
				return;
			end
			want = pending_steps.pop_front();
			if (want.hit !== hit || want.start !== start || want.len !== len) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (match/start/len)",
						$time, want.hit, want.start, want.len, hit, start, len);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          cmd;
	logic [7:0]          symbol;
	logic                out_valid;
	logic                out_ready;
	logic                match;
	logic [IDX_W-1:0]    start_index;
	logic [LEN_BITS-1:0] matched_length;

	rotation_scoreboard sb;
	bit                 tx_idle_on;
	bit                 rx_idle_on;
	int unsigned        words_sent;

	kmp_rotation_matcher #(
		.MAX_PATTERN(PAT_MAX),
		.INDEX_BITS (IDX_W)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.symbol        (symbol),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match         (match),
		.start_index   (start_index),
		.matched_length(matched_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Called at a rising edge; returns at the edge where the word is taken.
	// Valid stays high on return so a back-to-back word needs no second write.
	task automatic send_word(input logic [1:0] c, input logic [7:0] s);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		symbol <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_word(c, s);
		words_sent++;
	endtask

	task automatic pause_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_steps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_result(match, start_index, matched_length);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [7:0]  pat_q [$];
		logic [7:0]  letter_a;
		logic [7:0]  letter_b;
		logic [7:0]  b;
		logic [1:0]  c;
		int unsigned kind;
		int unsigned pick;
		int unsigned rot;
		int unsigned random_end;

		sb = new();
		in_valid <= 1'b0;
		cmd <= CMD_CLEAR;
		symbol <= 8'h00;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pattern, overlapping matches, the separator byte,
		// restart, an append in the middle of text, and clear.
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_word(CMD_TEXT, 8'h00);
		send_word(CMD_APPEND, 8'hFF);
		send_word(CMD_APPEND, 8'h00);
		send_word(CMD_APPEND, 8'hFF);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_TEXT, 8'h00);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_TEXT, 8'h00);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_TEXT, 8'h23);
		send_word(CMD_RESTART, 8'h00);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_APPEND, 8'h00);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_TEXT, 8'h00);
		send_word(CMD_TEXT, 8'hFF);
		send_word(CMD_TEXT, 8'h00);
		send_word(CMD_CLEAR, 8'hFF);
		send_word(CMD_TEXT, 8'h55);
		pause_for_drain();

		// A periodic pattern of full length gives deep failure chains; the
		// last append lands on a full store and must be dropped.
		send_word(CMD_CLEAR, 8'h00);
		for (int i = 0; i <= PAT_MAX; i++)
			send_word(CMD_APPEND, (i % 3 == 2) ? 8'h62 : 8'h61);
		for (int i = 0; i < PAT_MAX + 9; i++)
			send_word(CMD_TEXT, (i % 3 == 2) ? 8'h62 : 8'h61);
		repeat (5) send_word(CMD_TEXT, 8'($urandom_range(0, 255)));
		pause_for_drain();

		random_end = words_sent + RANDOM_WORDS;
		letter_a = 8'h61;
		letter_b = 8'h62;
		while (words_sent < random_end) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				if (pat_q.size() == 0 || $urandom_range(0, 3) != 0) begin
					send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
					pat_q.delete();
					letter_a = 8'($urandom_range(0, 255));
					letter_b = 8'($urandom_range(0, 255));
					repeat ($urandom_range(1, 8)) begin
						b = $urandom_range(0, 1) ? letter_a : letter_b;
						pat_q = {pat_q, b};
						send_word(CMD_APPEND, b);
					end
				end
				if ($urandom_range(0, 1)) begin
					// Stream a rotation twice, now and then with a corrupted byte.
					rot = $urandom_range(0, pat_q.size() - 1);
					repeat (2) begin
						for (int j = 0; j < pat_q.size(); j++) begin
							b = pat_q[(rot + j) % pat_q.size()];
							if ($urandom_range(0, 15) == 0)
								b = 8'($urandom_range(0, 255));
							send_word(CMD_TEXT, b);
						end
					end
				end else begin
					repeat ($urandom_range(4, 24))
						send_word(CMD_TEXT, $urandom_range(0, 1) ? letter_a : letter_b);
				end
				if ($urandom_range(0, 4) == 0)
					send_word(CMD_RESTART, 8'($urandom_range(0, 255)));
			end else if (kind == 7) begin
				repeat ($urandom_range(3, 12)) begin
					pick = $urandom_range(0, 9);
					c = (pick < 6) ? CMD_TEXT : (pick < 8) ? CMD_APPEND :
						(pick == 8) ? CMD_RESTART : CMD_CLEAR;
					send_word(c, 8'($urandom_range(0, 255)));
				end
			end else if (kind == 8) begin
				send_word(CMD_APPEND, letter_a);
				pat_q = {pat_q, letter_a};
				repeat (6)
					send_word(CMD_TEXT, $urandom_range(0, 1) ? letter_a : letter_b);
			end else begin
				pause_for_drain();
			end
		end

		pause_for_drain();
		repeat (12) @(posedge clk);
		$display("Checked %0d text results (%0d full matches) from %0d input words.",
			sb.results_seen, sb.hits_seen, words_sent);
		$display("Appends dropped on a full pattern: %0d.", sb.dropped_appends);
		if (sb.errors == 0 && sb.pending_steps.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/kmp_pkg.sv
rtl/kmp_cell.sv
rtl/kmp_tree.sv
rtl/kmp_rotation_matcher.sv
tb/sv/tb_top.sv
